// File: src/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared widths, constants and types of the RGB to HSV pixel unit.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

   // Channel and result widths
   localparam int CH_W  = 8;
   localparam int OUT_W = 15;

   // Stream widths, padded to whole bytes
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;

   // Full scale (100 * 256) and twice it, the latter used by the round-to-nearest forms
   localparam int HSV_FULL  = 25600;
   localparam int HSV_FULL2 = 2 * HSV_FULL;

   // Divider operand widths
   localparam int SAT_NUM_W = 24;  // 51200*delta + max < 2^24
   localparam int SAT_DEN_W = 9;   // 2*max
   localparam int HUE_NUM_W = 27;  // 51200*num + 6*delta < 2^27
   localparam int HUE_DEN_W = 12;  // 12*delta
   localparam int QUO_W     = 15;  // every quotient stays below 2^15

   // One divider stage per quotient bit
   localparam int DIV_STAGES = QUO_W;

   // Channel that holds the maximum; red wins ties over green, green over blue
   typedef enum logic [1:0] {
      SEL_RED   = 2'd0,
      SEL_GREEN = 2'd1,
      SEL_BLUE  = 2'd2
   } max_sel_type;

   // Operands handed from the front end to the divider
   typedef struct packed {
      logic [SAT_NUM_W-1:0] sat_num;
      logic [SAT_DEN_W-1:0] sat_den;
      logic [HUE_NUM_W-1:0] hue_num;
      logic [HUE_DEN_W-1:0] hue_den;
      logic [OUT_W-1:0]     val;
   } div_op_type;

endpackage

// File: src/rgbhsv_front.sv
// ----------------------------------------------------------------------------
// rgbhsv_front
// Two pipeline stages: find max, min and delta, then build the rounded
// division operands for saturation and hue and compute value directly.
// ----------------------------------------------------------------------------
module rgbhsv_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    in_vld,
   input  logic [rgbhsv_pkg::CH_W-1:0] in_red,
   input  logic [rgbhsv_pkg::CH_W-1:0] in_green,
   input  logic [rgbhsv_pkg::CH_W-1:0] in_blue,
   output logic                    out_vld,
   output rgbhsv_pkg::div_op_type  out_op
);
   import rgbhsv_pkg::*;

   // Stage 1 registers
   logic              vld1_ff;
   logic [CH_W-1:0]   red_ff, green_ff, blue_ff;
   logic [CH_W-1:0]   max_ff, max_in;
   logic [CH_W-1:0]   delta_ff, delta_in;
   max_sel_type       sel_ff, sel_in;
   logic [CH_W-1:0]   min_c;

   // Stage 2 registers
   logic              vld2_ff;
   div_op_type        op_ff, op_in;

   // Stage 2 working signals
   logic signed [11:0] d12;
   logic signed [11:0] num_raw;
   logic signed [11:0] num_adj;
   logic [11:0]        d6;
   logic [14:0]        val_base;
   logic [14:0]        val_y;
   logic [14:0]        val_q;

   // Find max, min and the winning channel
   always_comb begin
      max_in = in_red;
      min_c  = in_red;
      if (in_green > max_in) max_in = in_green;
      if (in_blue > max_in)  max_in = in_blue;
      if (in_green < min_c)  min_c = in_green;
      if (in_blue < min_c)   min_c = in_blue;
      delta_in = max_in - min_c;
      priority if (in_red == max_in) begin
         sel_in = SEL_RED;
      end else if (in_green == max_in) begin
         sel_in = SEL_GREEN;
      end else begin
         sel_in = SEL_BLUE;
      end
   end

   // Advance stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         red_ff   <= in_red;
         green_ff <= in_green;
         blue_ff  <= in_blue;
         max_ff   <= max_in;
         delta_ff <= delta_in;
         sel_ff   <= sel_in;
      end
   end

   // Sector numerator, wrapped into [0, 6*delta)
   always_comb begin
      d12 = $signed({4'b0, delta_ff});
      d6  = 12'({4'b0, delta_ff} << 2) + 12'({4'b0, delta_ff} << 1);
      unique case (sel_ff)
         SEL_RED: begin
            num_raw = $signed({4'b0, green_ff}) - $signed({4'b0, blue_ff});
         end
         SEL_GREEN: begin
            num_raw = (d12 <<< 1) + $signed({4'b0, blue_ff}) - $signed({4'b0, red_ff});
         end
         SEL_BLUE: begin
            num_raw = (d12 <<< 2) + $signed({4'b0, red_ff}) - $signed({4'b0, green_ff});
         end
         default: begin
            num_raw = '0;
         end
      endcase
      if (num_raw < 0) begin
         num_adj = num_raw + $signed(d6);
      end else begin
         num_adj = num_raw;
      end
   end

   // Build divider operands; a zero divisor is replaced by one with a zero numerator
   always_comb begin
      op_in.sat_num = SAT_NUM_W'(delta_ff) * SAT_NUM_W'(HSV_FULL2) + SAT_NUM_W'(max_ff);
      if (max_ff == '0) begin
         op_in.sat_den = SAT_DEN_W'(1);
      end else begin
         op_in.sat_den = {max_ff, 1'b0};
      end
      if (delta_ff == '0) begin
         op_in.hue_num = '0;
         op_in.hue_den = HUE_DEN_W'(1);
      end else begin
         op_in.hue_num = HUE_NUM_W'(num_adj[10:0]) * HUE_NUM_W'(HSV_FULL2)
                         + HUE_NUM_W'(d6);
         op_in.hue_den = HUE_DEN_W'(d6 << 1);
      end
      // value = 100*max + round(100*max/255); divide by 255 with the add-and-shift form
      val_base  = 15'({7'b0, max_ff} * 15'd100);
      val_y     = val_base + 15'd127;
      val_q     = 15'((val_y + 15'd1 + (val_y >> 8)) >> 8);
      op_in.val = val_base + val_q;
   end

   // Advance stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else if (adv) begin
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op_ff <= op_in;
      end
   end

   assign out_vld = vld2_ff;
   assign out_op  = op_ff;

endmodule

// File: src/rgbhsv_divider.sv
// ----------------------------------------------------------------------------
// rgbhsv_divider
// Pipelined restoring divider with two lanes (saturation and hue), one
// quotient bit per stage, most significant bit first. Value rides along.
// ----------------------------------------------------------------------------
module rgbhsv_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_vld,
   input  rgbhsv_pkg::div_op_type      in_op,
   output logic                        out_vld,
   output logic [rgbhsv_pkg::OUT_W-1:0] out_hue,
   output logic [rgbhsv_pkg::OUT_W-1:0] out_sat,
   output logic [rgbhsv_pkg::OUT_W-1:0] out_val
);
   import rgbhsv_pkg::*;

   // Per-stage registers
   logic                 vld_ff     [DIV_STAGES];
   logic [SAT_NUM_W-1:0] sat_rem_ff [DIV_STAGES];
   logic [SAT_DEN_W-1:0] sat_den_ff [DIV_STAGES];
   logic [QUO_W-1:0]     sat_q_ff   [DIV_STAGES];
   logic [HUE_NUM_W-1:0] hue_rem_ff [DIV_STAGES];
   logic [HUE_DEN_W-1:0] hue_den_ff [DIV_STAGES];
   logic [QUO_W-1:0]     hue_q_ff   [DIV_STAGES];
   logic [OUT_W-1:0]     val_ff     [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      localparam int BIT = QUO_W - 1 - s;

      logic                 vld_p;
      logic [SAT_NUM_W-1:0] sat_rem_p, sat_trial, sat_rem_in;
      logic [SAT_DEN_W-1:0] sat_den_p;
      logic [QUO_W-1:0]     sat_q_p, sat_q_in;
      logic [HUE_NUM_W-1:0] hue_rem_p, hue_trial, hue_rem_in;
      logic [HUE_DEN_W-1:0] hue_den_p;
      logic [QUO_W-1:0]     hue_q_p, hue_q_in;
      logic [OUT_W-1:0]     val_p;

      // Select the previous stage
      if (s == 0) begin : g_first
         assign vld_p     = in_vld;
         assign sat_rem_p = in_op.sat_num;
         assign sat_den_p = in_op.sat_den;
         assign sat_q_p   = '0;
         assign hue_rem_p = in_op.hue_num;
         assign hue_den_p = in_op.hue_den;
         assign hue_q_p   = '0;
         assign val_p     = in_op.val;
      end else begin : g_next
         assign vld_p     = vld_ff[s-1];
         assign sat_rem_p = sat_rem_ff[s-1];
         assign sat_den_p = sat_den_ff[s-1];
         assign sat_q_p   = sat_q_ff[s-1];
         assign hue_rem_p = hue_rem_ff[s-1];
         assign hue_den_p = hue_den_ff[s-1];
         assign hue_q_p   = hue_q_ff[s-1];
         assign val_p     = val_ff[s-1];
      end

      // Trial subtract of the shifted divisor, one quotient bit per lane
      always_comb begin
         sat_trial  = SAT_NUM_W'(sat_den_p) << BIT;
         sat_rem_in = sat_rem_p;
         sat_q_in   = sat_q_p;
         if (sat_rem_p >= sat_trial) begin
            sat_rem_in    = sat_rem_p - sat_trial;
            sat_q_in[BIT] = 1'b1;
         end
         hue_trial  = HUE_NUM_W'(hue_den_p) << BIT;
         hue_rem_in = hue_rem_p;
         hue_q_in   = hue_q_p;
         if (hue_rem_p >= hue_trial) begin
            hue_rem_in    = hue_rem_p - hue_trial;
            hue_q_in[BIT] = 1'b1;
         end
      end

      // Advance the stage valid
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= vld_p;
         end
      end

      // Advance the stage payload
      always_ff @(posedge clock) begin
         if (adv) begin
            sat_rem_ff[s] <= sat_rem_in;
            sat_den_ff[s] <= sat_den_p;
            sat_q_ff[s]   <= sat_q_in;
            hue_rem_ff[s] <= hue_rem_in;
            hue_den_ff[s] <= hue_den_p;
            hue_q_ff[s]   <= hue_q_in;
            val_ff[s]     <= val_p;
         end
      end
   end

   assign out_vld = vld_ff[DIV_STAGES-1];
   assign out_sat = sat_q_ff[DIV_STAGES-1];
   assign out_hue = hue_q_ff[DIV_STAGES-1];
   assign out_val = val_ff[DIV_STAGES-1];

`ifndef SYNTHESIS
   // A finished division leaves a remainder below its divisor
   a_sat_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DIV_STAGES-1] |->
         sat_rem_ff[DIV_STAGES-1] < SAT_NUM_W'(sat_den_ff[DIV_STAGES-1]))
      else $error("saturation remainder not below divisor");

   a_hue_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DIV_STAGES-1] |->
         hue_rem_ff[DIV_STAGES-1] < HUE_NUM_W'(hue_den_ff[DIV_STAGES-1]))
      else $error("hue remainder not below divisor");
`endif

endmodule

// File: src/rgb_to_hsv_pixel_unit.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_unit
// Converts one 8-bit RGB pixel per beat to hue, saturation and value in
// percent, unsigned Q7.8 (25600 is 100 percent), rounded to nearest.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one pixel per beat: red, green, blue bytes.
//   rsp_ channel carries one result per beat: hue, saturation, brightness.
//   Gray pixels give hue 0; black pixels give all three fields 0.
// Pipeline: 17 register stages, two front stages (max/min, operand build)
//   and a 15-stage divider pipeline, one quotient bit per stage.
// Throughput: one pixel per cycle; a new beat is taken every cycle while
//   the result side keeps up.
// Stall: the whole pipeline holds as one when a result waits on the output
//   register with rsp_tready low; req_tready drops at once and nothing is
//   lost or repeated. Bubbles keep their place while the pipe is held.
// Reset: synchronous, active high; clears all stage valid bits and holds
//   req_tready low, so the pipeline is empty and ready as soon as reset falls.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: red [7:0], green [15:8], blue [23:16]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [rgbhsv_pkg::REQ_DATA_W-1:0]    req_tdata,
   // rsp_tdata: hue [14:0], saturation [29:15], brightness [44:30], zero [47:45]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rgbhsv_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import rgbhsv_pkg::*;

   logic             adv;
   logic             front_vld;
   div_op_type       front_op;
   logic [OUT_W-1:0] hue, saturation, brightness;

   // Move every stage when the output register is free or being drained
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv && !reset;

   rgbhsv_front u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (req_tvalid),
      .in_red   (req_tdata[CH_W-1:0]),
      .in_green (req_tdata[2*CH_W-1:CH_W]),
      .in_blue  (req_tdata[3*CH_W-1:2*CH_W]),
      .out_vld  (front_vld),
      .out_op   (front_op)
   );

   // The last divider stage is the output register
   rgbhsv_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (front_vld),
      .in_op   (front_op),
      .out_vld (rsp_tvalid),
      .out_hue (hue),
      .out_sat (saturation),
      .out_val (brightness)
   );

   // Pack the result beat
   assign rsp_tdata = {(RSP_DATA_W - 3*OUT_W)'(0), brightness, saturation, hue};

`ifndef SYNTHESIS
   // A result held by the receiver stops the input side in the same cycle
   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input accepted while result stalled");

   // Results stay in their percent ranges
   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (hue < OUT_W'(HSV_FULL)) && (saturation <= OUT_W'(HSV_FULL))
                     && (brightness <= OUT_W'(HSV_FULL)))
      else $error("result out of range");
`endif

endmodule
